FILE: hw/rtl/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

	// Channel and result widths.
	localparam int CH_W    = 8;
	localparam int HUE_W   = 15;
	localparam int FRAC_W  = 12;
	localparam int NUM_H_W = CH_W + FRAC_W;
	localparam int NUM_S_W = CH_W + CH_W;

	// Hue constants in units of 1/64 degree.
	localparam logic [HUE_W-1:0] HUE_SIXTH = 15'd3840;
	localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
	localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

	// Saturation scale, 255 stands for 1.0.
	localparam logic [CH_W-1:0] SAT_SCALE = 8'd255;

	// Sector codes: which channel is the largest.
	localparam logic [1:0] SECT_RED   = 2'd0;
	localparam logic [1:0] SECT_GREEN = 2'd1;
	localparam logic [1:0] SECT_BLUE  = 2'd2;

	// Per-pixel tag that travels alongside the two divisions.
	typedef struct packed {
		logic            grey;
		logic [1:0]      sector;
		logic            neg;
		logic [CH_W-1:0] value;
	} tag_t;

	// Side data carried through the saturation divider.
	typedef struct packed {
		tag_t               tag;
		logic [NUM_H_W-1:0] num_h;
		logic [CH_W-1:0]    delta;
	} sat_side_t;

	// Side data carried through the hue divider.
	typedef struct packed {
		tag_t            tag;
		logic [CH_W-1:0] sat;
	} hue_side_t;

endpackage

FILE: hw/rtl/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module rgbhsv_div #(
	parameter int DEN_W  = 8,
	parameter int QUO_W  = 12,
	parameter int SIDE_W = 1,
	localparam int NUM_W = DEN_W + QUO_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	// Stage registers; entry k holds the state after quotient bit k is settled.
	logic [QUO_W-1:0]  vld_s;
	logic [DEN_W-1:0]  rem_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic [QUO_W-1:0]  num_s  [QUO_W];
	logic [DEN_W-1:0]  den_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];

	logic [QUO_W-1:0]  vld_d;
	logic [DEN_W-1:0]  rem_d  [QUO_W];
	logic [QUO_W-1:0]  quo_d  [QUO_W];
	logic [QUO_W-1:0]  num_d  [QUO_W];
	logic [DEN_W-1:0]  den_d  [QUO_W];
	logic [SIDE_W-1:0] side_d [QUO_W];

	// One shift-compare-subtract step per stage. The quotient must fit in
	// QUO_W bits, so the top DEN_W numerator bits start out below the divisor.
	always_comb begin
		logic              p_vld;
		logic [DEN_W-1:0]  p_rem;
		logic [QUO_W-1:0]  p_quo;
		logic [QUO_W-1:0]  p_num;
		logic [DEN_W-1:0]  p_den;
		logic [SIDE_W-1:0] p_side;
		logic [DEN_W:0]    trial;
		logic              ge;
		for (int k = 0; k < QUO_W; k++) begin
			if (k == 0) begin
				p_vld  = in_valid;
				p_rem  = num[NUM_W-1:QUO_W];
				p_quo  = '0;
				p_num  = num[QUO_W-1:0];
				p_den  = den;
				p_side = side;
			end else begin
				p_vld  = vld_s[k-1];
				p_rem  = rem_s[k-1];
				p_quo  = quo_s[k-1];
				p_num  = num_s[k-1];
				p_den  = den_s[k-1];
				p_side = side_s[k-1];
			end
			trial = {p_rem, p_num[QUO_W-1-k]};
			ge    = (trial >= {1'b0, p_den});
			if (ge) begin
				rem_d[k] = DEN_W'(trial - {1'b0, p_den});
			end else begin
				rem_d[k] = DEN_W'(trial);
			end
			vld_d[k]  = p_vld;
			quo_d[k]  = {p_quo[QUO_W-2:0], ge};
			num_d[k]  = p_num;
			den_d[k]  = p_den;
			side_d[k] = p_side;
		end
	end

	// Valid bits follow the data through every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_d;
		end
	end

	// Data registers, no reset needed.
	always_ff @(posedge clk) begin
		for (int k = 0; k < QUO_W; k++) begin
			rem_s[k]  <= rem_d[k];
			quo_s[k]  <= quo_d[k];
			num_s[k]  <= num_d[k];
			den_s[k]  <= den_d[k];
			side_s[k] <= side_d[k];
		end
	end

	assign out_valid = vld_s[QUO_W-1];
	assign quo       = quo_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];

endmodule

FILE: hw/rtl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, two dividers, hue assembly.
//
// One pixel is accepted in every clock cycle at which start is high; busy is
// always low because the pipeline never stalls. Each pixel leaves as one beat
// on hue, saturation and brightness, marked by done, in arrival order. The
// pipeline is made of the two restoring dividers, which settle one quotient bit
// per stage: 8 stages for saturation and 12 for hue, plus three front-end
// stages and the output register.
// Results cannot be held off, so the receiver must take every beat.
module rgb_to_hsv_converter
	import rgbhsv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             done,
	output logic [HUE_W-1:0] hue,
	output logic [CH_W-1:0]  saturation,
	output logic [CH_W-1:0]  brightness
);

	localparam int LATENCY = 3 + CH_W + FRAC_W + 1;
	localparam int SAT_SIDE_W = $bits(sat_side_t);
	localparam int HUE_SIDE_W = $bits(hue_side_t);

	// The pipeline moves every cycle, so it is never busy.
	assign busy = 1'b0;

	// Stage 1: register the input beat.
	logic            vld_s1;
	logic [CH_W-1:0] red_s1, green_s1, blue_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		red_s1   <= red;
		green_s1 <= green;
		blue_s1  <= blue;
	end

	// Stage 2: largest and smallest channel, sector and signed difference.
	logic            vld_s2;
	logic [CH_W-1:0] mx_s2, delta_s2, diff_s2;
	logic [1:0]      sector_s2;
	logic            neg_s2;

	logic [CH_W-1:0] mx_c, mn_c, rg_max, rg_min, pos_c, neg_c;
	logic [1:0]      sector_c;

	always_comb begin
		rg_max = (red_s1 > green_s1) ? red_s1 : green_s1;
		rg_min = (red_s1 < green_s1) ? red_s1 : green_s1;
		mx_c   = (rg_max > blue_s1) ? rg_max : blue_s1;
		mn_c   = (rg_min < blue_s1) ? rg_min : blue_s1;
		// Red wins ties over green, green over blue.
		if (red_s1 == mx_c) begin
			sector_c = SECT_RED;
			pos_c    = green_s1;
			neg_c    = blue_s1;
		end else if (green_s1 == mx_c) begin
			sector_c = SECT_GREEN;
			pos_c    = blue_s1;
			neg_c    = red_s1;
		end else begin
			sector_c = SECT_BLUE;
			pos_c    = red_s1;
			neg_c    = green_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mx_s2     <= mx_c;
		delta_s2  <= mx_c - mn_c;
		sector_s2 <= sector_c;
		neg_s2    <= (pos_c < neg_c);
		diff_s2   <= (pos_c < neg_c) ? (neg_c - pos_c) : (pos_c - neg_c);
	end

	// Stage 3: scale the two numerators by constants.
	logic               vld_s3;
	logic [NUM_H_W-1:0] num_h_s3;
	logic [NUM_S_W-1:0] num_s_s3;
	logic [CH_W-1:0]    delta_s3;
	tag_t               tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		num_h_s3      <= NUM_H_W'(diff_s2) * NUM_H_W'(HUE_SIXTH);
		num_s_s3      <= NUM_S_W'(delta_s2) * NUM_S_W'(SAT_SCALE);
		delta_s3      <= delta_s2;
		tag_s3.grey   <= (delta_s2 == '0);
		tag_s3.sector <= sector_s2;
		tag_s3.neg    <= neg_s2;
		tag_s3.value  <= mx_s2;
	end

	// Saturation divider: 255 * delta / max.
	sat_side_t sat_in_side, sat_out_side;
	logic      sat_vld;
	logic [CH_W-1:0] sat_quo;

	assign sat_in_side.tag   = tag_s3;
	assign sat_in_side.num_h = num_h_s3;
	assign sat_in_side.delta = delta_s3;

	rgbhsv_div #(
		.DEN_W (CH_W),
		.QUO_W (CH_W),
		.SIDE_W(SAT_SIDE_W)
	) u_sat_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.num      (num_s_s3),
		.den      (tag_s3.value),
		.side     (sat_in_side),
		.out_valid(sat_vld),
		.quo      (sat_quo),
		.out_side (sat_out_side)
	);

	// Hue divider: 3840 * difference / delta.
	hue_side_t hue_in_side, hue_out_side;
	logic      hue_vld;
	logic [FRAC_W-1:0] frac;

	assign hue_in_side.tag = sat_out_side.tag;
	// A black pixel would divide by zero; its saturation is zero.
	assign hue_in_side.sat = (sat_out_side.tag.value == '0) ? '0 : sat_quo;

	rgbhsv_div #(
		.DEN_W (CH_W),
		.QUO_W (FRAC_W),
		.SIDE_W(HUE_SIDE_W)
	) u_hue_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sat_vld),
		.num      (sat_out_side.num_h),
		.den      (sat_out_side.delta),
		.side     (hue_in_side),
		.out_valid(hue_vld),
		.quo      (frac),
		.out_side (hue_out_side)
	);

	// Stage 4: add the sector offset, wrap negative hues and zero the hue of grey pixels.
	logic             vld_s4;
	logic [HUE_W-1:0] hue_s4;
	logic [CH_W-1:0]  sat_s4, val_s4;

	logic [HUE_W-1:0] base_c, frac_c, hue_c;

	always_comb begin
		frac_c = HUE_W'(frac);
		case (hue_out_side.tag.sector)
			SECT_RED:   base_c = '0;
			SECT_GREEN: base_c = HUE_GREEN;
			SECT_BLUE:  base_c = HUE_BLUE;
			default:    base_c = '0;
		endcase
		if (hue_out_side.tag.grey) begin
			hue_c = '0;
		end else if (!hue_out_side.tag.neg) begin
			hue_c = base_c + frac_c;
		end else if (hue_out_side.tag.sector == SECT_RED && frac_c != '0) begin
			hue_c = HUE_FULL - frac_c;
		end else begin
			hue_c = base_c - frac_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= hue_vld;
		end
	end

	always_ff @(posedge clk) begin
		hue_s4 <= hue_c;
		sat_s4 <= hue_out_side.sat;
		val_s4 <= hue_out_side.tag.value;
	end

	assign done       = vld_s4;
	assign hue        = hue_s4;
	assign saturation = sat_s4;
	assign brightness = val_s4;

`ifndef NO_ASSERTIONS
	// Every result beat comes from an accepted pixel a fixed time earlier.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without a matching input beat");

	// Every accepted pixel yields a result beat after the fixed latency.
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("input beat lost in the pipeline");

	// Hue stays below a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue < HUE_FULL))
		else $error("hue out of range");

	// A black pixel has zero hue and saturation.
	a_black_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && brightness == '0) |-> (hue == '0 && saturation == '0))
		else $error("black pixel with nonzero hue or saturation");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the RGB to HSV converter pipeline.
`timescale 1ns / 100ps

module tb_top
	import rgbhsv_pkg::*;
();

	// Cycles without any beat on either side before the run is declared hung.
	localparam int STALL_LIMIT = 1000;
	// Quiet cycles after the last result, more than the pipeline depth.
	localparam int DRAIN_CYCLES = 40;

	// One converted pixel as it appears on the result ports.
	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [CH_W-1:0]  red = '0;
	logic [CH_W-1:0]  green = '0;
	logic [CH_W-1:0]  blue = '0;
	logic             busy;
	logic             done;
	logic [HUE_W-1:0] hue;
	logic [CH_W-1:0]  saturation;
	logic [CH_W-1:0]  brightness;

	hsv_t hsv_pending[$];
	hsv_t hsv_head;
	int   mismatches = 0;
	int   pixels_sent = 0;
	int   pixels_checked = 0;
	int   quiet_cycles = 0;

	rgb_to_hsv_converter u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	// Free-running 2 ns clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected hue, saturation and value of one pixel, hue in 1/64 degree.
	function automatic hsv_t calc_hsv(input logic [CH_W-1:0] r, g, b);
		int   mx;
		int   mn;
		int   delta;
		int   base;
		int   pos;
		int   neg;
		int   h;
		hsv_t res;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		delta = mx - mn;
		res.val = mx[CH_W-1:0];
		res.sat = (mx != 0) ? CH_W'((255 * delta) / mx) : '0;
		h = 0;
		if (delta != 0) begin
			// Red wins ties over green, green wins over blue.
			if (r == mx) begin
				base = 0;
				pos = g;
				neg = b;
			end else if (g == mx) begin
				base = int'(HUE_GREEN);
				pos = b;
				neg = r;
			end else begin
				base = int'(HUE_BLUE);
				pos = r;
				neg = g;
			end
			// Divide the magnitude so the quotient truncates toward zero.
			if (pos >= neg)
				h = base + (int'(HUE_SIXTH) * (pos - neg)) / delta;
			else
				h = base - (int'(HUE_SIXTH) * (neg - pos)) / delta;
			if (h < 0)
				h += int'(HUE_FULL);
		end
		res.hue = h[HUE_W-1:0];
		return res;
	endfunction

	// Record each accepted pixel and compare each result beat in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				hsv_pending.push_back(calc_hsv(red, green, blue));
			if (done) begin
				if (hsv_pending.size() == 0) begin
					$error("result beat with no pixel outstanding: hue=%0d sat=%0d val=%0d",
						hue, saturation, brightness);
					mismatches++;
				end else begin
					hsv_head = hsv_pending.pop_front();
					pixels_checked++;
					if (hue !== hsv_head.hue) begin
						$error("hue: expected %0d, got %0d", hsv_head.hue, hue);
						mismatches++;
					end
					if (saturation !== hsv_head.sat) begin
						$error("saturation: expected %0d, got %0d", hsv_head.sat, saturation);
						mismatches++;
					end
					if (brightness !== hsv_head.val) begin
						$error("brightness: expected %0d, got %0d", hsv_head.val, brightness);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog: the run is hung if no beat moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat for %0d cycles, %0d results outstanding",
					STALL_LIMIT, hsv_pending.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Present one pixel and hold it until the converter takes the beat.
	task automatic send_pixel(input logic [CH_W-1:0] r, g, b);
		start <= 1'b1;
		red   <= r;
		green <= g;
		blue  <= b;
		do
			@(posedge clk);
		while (busy);
		pixels_sent++;
	endtask

	// Drop start for a number of cycles with noise on the channel inputs.
	task automatic idle_gap(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			red   <= CH_W'($urandom);
			green <= CH_W'($urandom);
			blue  <= CH_W'($urandom);
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Corners: black, white, grey, primaries, ties and wrapped hues.
	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd0,   8'd1,   8'd255);
		send_pixel(8'd1,   8'd0,   8'd255);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd1);
		send_pixel(8'd170, 8'd85,  8'd0);
		send_pixel(8'd254, 8'd255, 8'd254);
		send_pixel(8'd85,  8'd170, 8'd255);
		idle_gap(pick_gap());
	endtask

	// Uniform random pixels with random pauses between them.
	task automatic test_random_pixels(input int count);
		repeat (count) begin
			send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
			idle_gap(pick_gap());
		end
	endtask

	// Nearly grey pixels, where delta is small and the divisions are touchy.
	task automatic test_low_delta_pixels(input int count);
		int base;
		repeat (count) begin
			base = $urandom_range(0, 255);
			send_pixel(CH_W'(base), CH_W'(base ^ $urandom_range(0, 3)),
				CH_W'(base ^ $urandom_range(0, 3)));
			idle_gap(pick_gap());
		end
	endtask

	// Ties on the largest channel with the third one random.
	task automatic test_tied_max_pixels(input int count);
		logic [CH_W-1:0] hi;
		logic [CH_W-1:0] other;
		repeat (count) begin
			hi = CH_W'($urandom);
			other = CH_W'($urandom_range(0, hi));
			case ($urandom_range(0, 2))
				0: send_pixel(hi, hi, other);
				1: send_pixel(hi, other, hi);
				default: send_pixel(other, hi, hi);
			endcase
			idle_gap(pick_gap());
		end
	endtask

	// A full-rate stream with a beat in every cycle.
	task automatic test_full_rate_stream(input int count);
		repeat (count)
			send_pixel(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
		idle_gap(1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pixels();
		test_random_pixels(500);
		test_low_delta_pixels(150);
		test_tied_max_pixels(100);
		test_full_rate_stream(180);

		// Let the pipeline drain, then watch for stray result beats.
		start <= 1'b0;
		while (hsv_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels (corners, random, near-grey, tied, full-rate);",
			pixels_sent);
		$display("checked %0d results, %0d mismatches.", pixels_checked, mismatches);
		if (mismatches == 0 && hsv_pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
